### rtl/core/hri_pkg.sv
// Shared constants, types and register codes for the Herzberger refractive index block.
`timescale 1ns / 1ps

package hri_pkg;

    localparam int WL_W     = 24;
    localparam int COEF_W   = 48;
    localparam int IDX_W    = 48;
    localparam int SQ_W     = 2 * WL_W;
    localparam int FRAC_SH  = 10;
    localparam int LAM2_W   = 45;
    localparam int LAM4_W   = 58;
    localparam int LAM6_W   = 63;
    localparam int RREM_W   = LAM2_W + 1;
    localparam int LM_W     = 54;
    localparam int RCP_ST   = LM_W;
    localparam int L2_W     = 64;
    localparam int MUL_W    = 64;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int MUL_LAT  = 3;
    localparam int TERM_W   = 60;
    localparam int SUM_W    = 63;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;
    localparam int REG_SEL_W = 3;

    localparam int SH_L     = 44;
    localparam int SH_LAM   = 32;
    localparam int SH_LAM6  = 24;
    localparam int SH_L4    = 32;
    localparam int SH_L6    = 40;
    localparam int DIV_SH   = 72;

    localparam logic [MUL_W-1:0]    DIV_M      = 64'd302231454903657294;
    localparam logic [LAM2_W-1:0]   K_0028     = 45'd120259084;
    localparam logic [LAM2_W-1:0]   POLE_BAND  = 45'd4194304;
    localparam logic [RREM_W-1:0]   RCP_INIT   = 46'd4194304;
    localparam logic [LM_W-1:0]     L_MAX      = '1;
    localparam logic [TERM_W-2:0]   TERM_MAX   = '1;
    localparam logic signed [SUM_W-1:0] IDX_MAX = 63'sd140737488355327;
    localparam logic signed [SUM_W-1:0] IDX_MIN = -IDX_MAX - 63'sd1;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_COEF_D,
        REG_COEF_E,
        REG_COEF_F,
        REG_MIN_WL,
        REG_MAX_WL
    } reg_idx_t;

    typedef struct packed {
        logic            v;
        logic            oor;
        logic [WL_W-1:0] w;
    } in_t;

    typedef struct packed {
        logic            v;
        logic            oor;
        logic [SQ_W-1:0] sq;
    } div_t;

    typedef struct packed {
        logic              v;
        logic              oor;
        logic              lneg;
        logic              pole;
        logic [LAM2_W-1:0] lam2;
        logic [LAM2_W-1:0] dm;
        logic [RREM_W-1:0] rem;
        logic [LM_W-1:0]   quo;
    } rcp_t;

    typedef struct packed {
        logic              v;
        logic              oor;
        logic              lneg;
        logic              pole;
        logic [LAM2_W-1:0] lam2;
        logic [LM_W-1:0]   lm;
    } side_t;

    typedef struct packed {
        logic                     clip;
        logic signed [TERM_W-1:0] val;
    } term_t;

    typedef struct packed {
        logic                     v;
        logic                     oor;
        logic                     clip;
        logic [LAM2_W-1:0]        lam2;
        logic [LAM4_W-1:0]        lam4;
        logic [L2_W-1:0]          l2;
        logic signed [TERM_W-1:0] tb;
        logic signed [TERM_W-1:0] td;
    } e_t;

    typedef struct packed {
        logic                     v;
        logic                     oor;
        logic                     clip;
        logic [LAM6_W-1:0]        lam6;
        logic signed [TERM_W-1:0] tb;
        logic signed [TERM_W-1:0] tc;
        logic signed [TERM_W-1:0] td;
        logic signed [TERM_W-1:0] te;
    } f_t;

    typedef struct packed {
        logic                     v;
        logic                     oor;
        logic                     clip;
        logic signed [TERM_W-1:0] tb;
        logic signed [TERM_W-1:0] tc;
        logic signed [TERM_W-1:0] td;
        logic signed [TERM_W-1:0] te;
        logic signed [TERM_W-1:0] tf;
    } g_t;

    typedef struct packed {
        logic                    v;
        logic                    oor;
        logic                    clip;
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
    } sum_t;

    typedef struct packed {
        logic                    v;
        logic                    oor;
        logic                    sat;
        logic signed [IDX_W-1:0] index;
    } res_t;

endpackage

### rtl/core/hri_mul64.sv
// Three-stage unsigned 64 by 64 multiplier built from 32-bit partial products.
`timescale 1ns / 1ps

module hri_mul64
    import hri_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    localparam int HALF = MUL_W / 2;

    logic [MUL_W-1:0]  ll_reg;
    logic [MUL_W-1:0]  lh_reg;
    logic [MUL_W-1:0]  hl_reg;
    logic [MUL_W-1:0]  hh_reg;
    logic [MUL_W-1:0]  ll2_reg;
    logic [MUL_W-1:0]  hh2_reg;
    logic [MUL_W:0]    mid_reg;
    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= MUL_W'(a[HALF-1:0]) * MUL_W'(b[HALF-1:0]);
            lh_reg  <= MUL_W'(a[HALF-1:0]) * MUL_W'(b[MUL_W-1:HALF]);
            hl_reg  <= MUL_W'(a[MUL_W-1:HALF]) * MUL_W'(b[HALF-1:0]);
            hh_reg  <= MUL_W'(a[MUL_W-1:HALF]) * MUL_W'(b[MUL_W-1:HALF]);
            mid_reg <= {1'b0, lh_reg} + {1'b0, hl_reg};
            ll2_reg <= ll_reg;
            hh2_reg <= hh_reg;
            p_reg   <= {hh2_reg, ll2_reg} + {{(HALF-1){1'b0}}, mid_reg, {HALF{1'b0}}};
        end
    end

    assign p = p_reg;

endmodule

### rtl/core/herzberger_refractive_index_top.sv
// Top level of the Herzberger refractive index pipeline with its register port.
`timescale 1ns / 1ps

// The block takes one wavelength word (nm, 8 fraction bits) on the input channel
// and returns one word per wavelength on the output channel: the refractive index
// in signed Q4.44 with an out-of-range flag and a saturation flag.
// Coefficients and wavelength limits are written through the register port; the
// user must write them only while the block is idle, which the block itself does
// not enforce. Each register sits at byte address 8 times its number. One wavelength
// can enter every cycle unless a stalled output holds the pipeline. The depth comes
// from the squaring stage, the division by the constant that forms lambda squared (a
// three-stage reciprocal multiply), the reciprocal divider (54 stages, one quotient
// bit each), three rounds of pipelined 64-bit multipliers and a four-stage adder tree
// with the final clamp. Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the output word holds; the pipeline keeps moving
// until its last stage holds a word, and only then stops taking input.

module herzberger_refractive_index_top
    import hri_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [WL_W-1:0]          wavelength,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [IDX_W-1:0]  index,
    output logic                     out_of_range,
    output logic                     saturated
);

    logic signed [COEF_W-1:0] coef_a_reg;
    logic signed [COEF_W-1:0] coef_b_reg;
    logic signed [COEF_W-1:0] coef_c_reg;
    logic signed [COEF_W-1:0] coef_d_reg;
    logic signed [COEF_W-1:0] coef_e_reg;
    logic signed [COEF_W-1:0] coef_f_reg;
    logic [WL_W-1:0]          min_wl_reg;
    logic [WL_W-1:0]          max_wl_reg;
    reg_idx_t                 reg_sel;

    logic adv;
    logic hold;

    in_t   s0_reg, s0_next;
    div_t  d_reg  [MUL_LAT+1];
    div_t  d0_next;
    rcp_t  p_reg, p_next;
    rcp_t  r_reg  [RCP_ST];
    rcp_t  r_next [RCP_ST];
    side_t c_reg  [MUL_LAT+1];
    side_t c0_next;
    e_t    e_reg  [MUL_LAT+1];
    e_t    e0_next;
    f_t    f_reg  [MUL_LAT+1];
    f_t    f0_next;
    g_t    g_reg, g_next;
    sum_t  h0_reg, h0_next;
    sum_t  h1_reg, h1_next;
    sum_t  h2_reg, h2_next;
    res_t  h3_reg, h3_next;

    logic                    out_valid_reg;
    logic signed [IDX_W-1:0] index_reg;
    logic                    oor_reg;
    logic                    sat_reg;

    logic [SQ_W-1:0]   sq_full;
    logic [COEF_W-1:0] mag_b, mag_c, mag_d, mag_e, mag_f;
    logic [PROD_W-1:0] prod_q;
    logic [PROD_W-1:0] prod_l2, prod_l4, prod_b, prod_d;
    logic [PROD_W-1:0] prod_c, prod_e, prod_l6, prod_f;

    function automatic logic [COEF_W-1:0] coef_mag(input logic [COEF_W-1:0] c);
        return c[COEF_W-1] ? (~c + 1'b1) : c;
    endfunction

    function automatic term_t make_term(input logic [PROD_W-1:0] prod, input int sh,
                                        input logic neg);
        logic [PROD_W-1:0] mag;
        logic [TERM_W-1:0] q;
        term_t             res;
        mag      = prod >> sh;
        res.clip = |mag[PROD_W-1:TERM_W-1];
        q        = res.clip ? {1'b0, TERM_MAX} : {1'b0, mag[TERM_W-2:0]};
        res.val  = neg ? -$signed(q) : $signed(q);
        return res;
    endfunction

    // Register port.
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:PADDR_W-REG_SEL_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            coef_e_reg <= '0;
            coef_f_reg <= '0;
            min_wl_reg <= '0;
            max_wl_reg <= '1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_COEF_A: coef_a_reg <= pwdata[COEF_W-1:0];
                REG_COEF_B: coef_b_reg <= pwdata[COEF_W-1:0];
                REG_COEF_C: coef_c_reg <= pwdata[COEF_W-1:0];
                REG_COEF_D: coef_d_reg <= pwdata[COEF_W-1:0];
                REG_COEF_E: coef_e_reg <= pwdata[COEF_W-1:0];
                REG_COEF_F: coef_f_reg <= pwdata[COEF_W-1:0];
                REG_MIN_WL: min_wl_reg <= pwdata[WL_W-1:0];
                REG_MAX_WL: max_wl_reg <= pwdata[WL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_COEF_A: prdata = PDATA_W'(unsigned'(coef_a_reg));
            REG_COEF_B: prdata = PDATA_W'(unsigned'(coef_b_reg));
            REG_COEF_C: prdata = PDATA_W'(unsigned'(coef_c_reg));
            REG_COEF_D: prdata = PDATA_W'(unsigned'(coef_d_reg));
            REG_COEF_E: prdata = PDATA_W'(unsigned'(coef_e_reg));
            REG_COEF_F: prdata = PDATA_W'(unsigned'(coef_f_reg));
            REG_MIN_WL: prdata = PDATA_W'(min_wl_reg);
            REG_MAX_WL: prdata = PDATA_W'(max_wl_reg);
            default:    prdata = '0;
        endcase
    end

    // Pipeline control: everything moves together unless the output word is
    // stalled and the last stage already holds a word.
    assign hold     = out_valid_reg && !out_ready;
    assign adv      = !hold || !h3_reg.v;
    assign in_ready = adv;

    assign mag_b = coef_mag(coef_b_reg);
    assign mag_c = coef_mag(coef_c_reg);
    assign mag_d = coef_mag(coef_d_reg);
    assign mag_e = coef_mag(coef_e_reg);
    assign mag_f = coef_mag(coef_f_reg);

    // Input capture and range check.
    always_comb
    begin
        s0_next.v   = in_valid;
        s0_next.oor = (wavelength < min_wl_reg) || (wavelength > max_wl_reg);
        s0_next.w   = wavelength;
    end

    // Wavelength squared.
    assign sq_full = SQ_W'(s0_reg.w) * SQ_W'(s0_reg.w);

    always_comb
    begin
        d0_next.v   = s0_reg.v;
        d0_next.oor = s0_reg.oor;
        d0_next.sq  = sq_full;
    end

    // Division of sq * 1024 by 15625 as a multiply by a scaled reciprocal. The
    // reciprocal is rounded up, which keeps the quotient exact over the whole range.
    hri_mul64 u_mul_q  (.clk(clk), .en(adv), .a(MUL_W'({d_reg[0].sq, {FRAC_SH{1'b0}}})),
                        .b(DIV_M), .p(prod_q));

    // Distance from the pole.
    always_comb
    begin
        logic [LAM2_W-1:0] lam2;
        lam2         = prod_q[DIV_SH +: LAM2_W];
        p_next.v     = d_reg[MUL_LAT].v;
        p_next.oor   = d_reg[MUL_LAT].oor;
        p_next.lam2  = lam2;
        p_next.lneg  = lam2 < K_0028;
        p_next.dm    = (lam2 < K_0028) ? (K_0028 - lam2) : (lam2 - K_0028);
        p_next.pole  = p_next.dm <= POLE_BAND;
        p_next.rem   = RCP_INIT;
        p_next.quo   = '0;
    end

    // Reciprocal 2^76 / dm, one quotient bit per stage.
    always_comb
    begin
        rcp_t              cur;
        logic [RREM_W-1:0] trial;
        for (int j = 0; j < RCP_ST; j++)
        begin
            cur   = (j == 0) ? p_reg : r_reg[j-1];
            trial = {cur.rem[RREM_W-2:0], 1'b0};
            if (trial >= {1'b0, cur.dm})
            begin
                cur.rem = trial - {1'b0, cur.dm};
                cur.quo = {cur.quo[LM_W-2:0], 1'b1};
            end
            else
            begin
                cur.rem = trial;
                cur.quo = {cur.quo[LM_W-2:0], 1'b0};
            end
            r_next[j] = cur;
        end
    end

    always_comb
    begin
        c0_next.v    = r_reg[RCP_ST-1].v;
        c0_next.oor  = r_reg[RCP_ST-1].oor;
        c0_next.lneg = r_reg[RCP_ST-1].lneg;
        c0_next.pole = r_reg[RCP_ST-1].pole;
        c0_next.lam2 = r_reg[RCP_ST-1].lam2;
        c0_next.lm   = r_reg[RCP_ST-1].pole ? L_MAX : r_reg[RCP_ST-1].quo;
    end

    // First multiplier round: L^2, lambda^4, B*L, D*lambda^2.
    hri_mul64 u_mul_l2 (.clk(clk), .en(adv), .a(MUL_W'(c_reg[0].lm)),
                        .b(MUL_W'(c_reg[0].lm)), .p(prod_l2));
    hri_mul64 u_mul_l4 (.clk(clk), .en(adv), .a(MUL_W'(c_reg[0].lam2)),
                        .b(MUL_W'(c_reg[0].lam2)), .p(prod_l4));
    hri_mul64 u_mul_b  (.clk(clk), .en(adv), .a(MUL_W'(mag_b)),
                        .b(MUL_W'(c_reg[0].lm)), .p(prod_b));
    hri_mul64 u_mul_d  (.clk(clk), .en(adv), .a(MUL_W'(mag_d)),
                        .b(MUL_W'(c_reg[0].lam2)), .p(prod_d));

    always_comb
    begin
        term_t tb;
        term_t td;
        tb = make_term(prod_b, SH_L, coef_b_reg[COEF_W-1] ^ c_reg[MUL_LAT].lneg);
        td = make_term(prod_d, SH_LAM, coef_d_reg[COEF_W-1]);
        e0_next.v    = c_reg[MUL_LAT].v;
        e0_next.oor  = c_reg[MUL_LAT].oor;
        e0_next.clip = c_reg[MUL_LAT].pole | tb.clip | td.clip;
        e0_next.lam2 = c_reg[MUL_LAT].lam2;
        e0_next.lam4 = prod_l4[SH_L4 +: LAM4_W];
        e0_next.l2   = prod_l2[SH_L +: L2_W];
        e0_next.tb   = tb.val;
        e0_next.td   = td.val;
    end

    // Second round: C*L^2, E*lambda^4, lambda^6.
    hri_mul64 u_mul_c  (.clk(clk), .en(adv), .a(MUL_W'(mag_c)),
                        .b(e_reg[0].l2), .p(prod_c));
    hri_mul64 u_mul_e  (.clk(clk), .en(adv), .a(MUL_W'(mag_e)),
                        .b(MUL_W'(e_reg[0].lam4)), .p(prod_e));
    hri_mul64 u_mul_l6 (.clk(clk), .en(adv), .a(MUL_W'(e_reg[0].lam4)),
                        .b(MUL_W'(e_reg[0].lam2)), .p(prod_l6));

    always_comb
    begin
        term_t tc;
        term_t te;
        tc = make_term(prod_c, SH_L, coef_c_reg[COEF_W-1]);
        te = make_term(prod_e, SH_LAM, coef_e_reg[COEF_W-1]);
        f0_next.v    = e_reg[MUL_LAT].v;
        f0_next.oor  = e_reg[MUL_LAT].oor;
        f0_next.clip = e_reg[MUL_LAT].clip | tc.clip | te.clip;
        f0_next.lam6 = prod_l6[SH_L6 +: LAM6_W];
        f0_next.tb   = e_reg[MUL_LAT].tb;
        f0_next.tc   = tc.val;
        f0_next.td   = e_reg[MUL_LAT].td;
        f0_next.te   = te.val;
    end

    // Third round: F*lambda^6.
    hri_mul64 u_mul_f  (.clk(clk), .en(adv), .a(MUL_W'(mag_f)),
                        .b(MUL_W'(f_reg[0].lam6)), .p(prod_f));

    always_comb
    begin
        term_t tf;
        tf = make_term(prod_f, SH_LAM6, coef_f_reg[COEF_W-1]);
        g_next.v    = f_reg[MUL_LAT].v;
        g_next.oor  = f_reg[MUL_LAT].oor;
        g_next.clip = f_reg[MUL_LAT].clip | tf.clip;
        g_next.tb   = f_reg[MUL_LAT].tb;
        g_next.tc   = f_reg[MUL_LAT].tc;
        g_next.td   = f_reg[MUL_LAT].td;
        g_next.te   = f_reg[MUL_LAT].te;
        g_next.tf   = tf.val;
    end

    // Adder tree and final clamp.
    always_comb
    begin
        h0_next.v    = g_reg.v;
        h0_next.oor  = g_reg.oor;
        h0_next.clip = g_reg.clip;
        h0_next.s0   = SUM_W'(coef_a_reg) + SUM_W'(g_reg.tb);
        h0_next.s1   = SUM_W'(g_reg.tc) + SUM_W'(g_reg.td);
        h0_next.s2   = SUM_W'(g_reg.te) + SUM_W'(g_reg.tf);

        h1_next      = h0_reg;
        h1_next.s0   = h0_reg.s0 + h0_reg.s1;
        h1_next.s1   = '0;

        h2_next      = h1_reg;
        h2_next.s0   = h1_reg.s0 + h1_reg.s2;
        h2_next.s2   = '0;

        h3_next.v    = h2_reg.v;
        h3_next.oor  = h2_reg.oor;
        if (h2_reg.oor)
        begin
            h3_next.index = '0;
            h3_next.sat   = 1'b0;
        end
        else if (h2_reg.s0 > IDX_MAX)
        begin
            h3_next.index = IDX_W'(IDX_MAX);
            h3_next.sat   = 1'b1;
        end
        else if (h2_reg.s0 < IDX_MIN)
        begin
            h3_next.index = IDX_W'(IDX_MIN);
            h3_next.sat   = 1'b1;
        end
        else
        begin
            h3_next.index = IDX_W'(h2_reg.s0);
            h3_next.sat   = h2_reg.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            p_reg <= '0;
            for (int j = 0; j < RCP_ST; j++)
            begin
                r_reg[j] <= '0;
            end
            for (int j = 0; j <= MUL_LAT; j++)
            begin
                d_reg[j] <= '0;
                c_reg[j] <= '0;
                e_reg[j] <= '0;
                f_reg[j] <= '0;
            end
            g_reg  <= '0;
            h0_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
            h3_reg <= '0;
        end
        else if (adv)
        begin
            s0_reg <= s0_next;
            p_reg <= p_next;
            for (int j = 0; j < RCP_ST; j++)
            begin
                r_reg[j] <= r_next[j];
            end
            d_reg[0] <= d0_next;
            c_reg[0] <= c0_next;
            e_reg[0] <= e0_next;
            f_reg[0] <= f0_next;
            for (int j = 1; j <= MUL_LAT; j++)
            begin
                d_reg[j] <= d_reg[j-1];
                c_reg[j] <= c_reg[j-1];
                e_reg[j] <= e_reg[j-1];
                f_reg[j] <= f_reg[j-1];
            end
            g_reg  <= g_next;
            h0_reg <= h0_next;
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            h3_reg <= h3_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
            oor_reg       <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else if (!hold)
        begin
            out_valid_reg <= h3_reg.v;
            index_reg     <= h3_reg.index;
            oor_reg       <= h3_reg.oor;
            sat_reg       <= h3_reg.sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign index        = index_reg;
    assign out_of_range = oor_reg;
    assign saturated    = sat_reg;

endmodule
